@@ rtl/ltc_pkg.sv @@
// Shared types, constants and the lookup function for the lemniscate tracking controller.
package ltc_pkg;

  // Iteration counts and widths
  localparam int CORDIC_STEPS = 16;
  localparam int TICK_BITS    = 32;
  localparam int MUL_STEPS    = 32;
  localparam int DIV_STEPS    = 64;

  // Fixed-point constants
  localparam logic [31:0]        PHASE_MOD    = 32'd411774832;
  localparam logic signed [21:0] Q_PI         = 22'sd205887;
  localparam logic signed [21:0] Q_HALF_PI    = 22'sd102944;
  localparam logic signed [21:0] Q_TWO_PI     = 22'sd411775;
  localparam logic signed [63:0] SQRT2_Q30    = 64'sd1518500250;
  localparam logic signed [39:0] CORDIC_K_Q30 = 40'sd652032874;
  localparam logic signed [63:0] VEL_LIMIT    = 64'sd35184372088832;
  localparam logic signed [63:0] ONE_Q30      = 64'sd1073741824;
  localparam logic [31:0]        MS_PER_S     = 32'd1000;

  // Register map
  typedef enum logic [2:0] {
    REG_GAIN   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_PERIOD = 3'd2,
    REG_AMP    = 3'd3,
    REG_RATE   = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE,
    O_M1, O_M2, O_M3, O_M4, O_VEC,
    T_NMOD, T_RMUL, T_RMOD, T_AMP,
    P_PH, P_ROT, P_SS, P_AC, P_XD, P_CS, P_ACS, P_YD,
    F_GX, F_DX, F_FX, F_GY, F_DY, F_FY,
    H_ROT, H_M1, H_M2, H_M3, H_M4, H_WD,
    S_OUT
  } state_t;

  // Requests from the sequencer to the arithmetic units
  typedef struct packed {
    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [32:0] mul_b;
    logic               div_start;
    logic signed [63:0] div_a;
    logic [31:0]        div_b;
    logic               cor_start;
    logic               cor_vec;
    logic signed [21:0] cor_ang;
    logic signed [35:0] cor_vx;
    logic signed [35:0] cor_vy;
  } arith_req_t;

  // Results and status back to the sequencer
  typedef struct packed {
    logic               busy;
    logic signed [63:0] mul_p;
    logic signed [63:0] div_q;
    logic [31:0]        div_r;
    logic signed [31:0] cor_c;
    logic signed [31:0] cor_s;
    logic signed [21:0] cor_z;
  } arith_rsp_t;

  // Arctangent table, Q16.16 radians
  function automatic logic [15:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:    atan_entry = 16'd51472;
      5'd1:    atan_entry = 16'd30386;
      5'd2:    atan_entry = 16'd16055;
      5'd3:    atan_entry = 16'd8150;
      5'd4:    atan_entry = 16'd4091;
      5'd5:    atan_entry = 16'd2047;
      5'd6:    atan_entry = 16'd1024;
      5'd7:    atan_entry = 16'd512;
      5'd8:    atan_entry = 16'd256;
      5'd9:    atan_entry = 16'd128;
      5'd10:   atan_entry = 16'd64;
      5'd11:   atan_entry = 16'd32;
      5'd12:   atan_entry = 16'd16;
      5'd13:   atan_entry = 16'd8;
      5'd14:   atan_entry = 16'd4;
      5'd15:   atan_entry = 16'd2;
      5'd16:   atan_entry = 16'd1;
      default: atan_entry = 16'd0;
    endcase
  endfunction

endpackage

@@ rtl/ltc_arith.sv @@
// Bit-serial multiplier, bit-serial divider and iterative CORDIC shared by the sequencer.
module ltc_arith (
  input  logic               clk,
  input  logic               rst,
  input  ltc_pkg::arith_req_t req,
  output ltc_pkg::arith_rsp_t rsp
);
  import ltc_pkg::*;

  localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS - 1);
  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);
  localparam logic [4:0] COR_LAST = 5'(CORDIC_STEPS - 1);

  // Multiplier: one multiplier bit per cycle
  logic               mul_busy;
  logic [4:0]         mul_cnt;
  logic [63:0]        mul_acc;
  logic [63:0]        mul_mcand;
  logic [31:0]        mul_mplier;
  logic               mul_neg;
  logic signed [32:0] mul_b_abs;
  logic signed [63:0] mul_a_abs;

  // Divider: one quotient bit per cycle
  logic               div_busy;
  logic [5:0]         div_cnt;
  logic [31:0]        div_rem;
  logic [63:0]        div_quo;
  logic [31:0]        div_den;
  logic               div_neg;
  logic [32:0]        div_trial;
  logic               div_ge;
  logic [32:0]        div_diff;

  // CORDIC: one micro-rotation per cycle
  logic               cor_busy;
  logic [4:0]         cor_i;
  logic signed [39:0] cor_x;
  logic signed [39:0] cor_y;
  logic signed [21:0] cor_z;
  logic               cor_vec;
  logic               cor_neg;
  logic signed [39:0] cor_dx;
  logic signed [39:0] cor_dy;
  logic signed [21:0] cor_atan;
  logic               cor_dir;
  logic signed [39:0] cor_c_full;
  logic signed [39:0] cor_s_full;

  // Angle fold for rotation mode
  logic signed [21:0] z0, z1, z2, z3, z4, fold_z;
  logic               fold_neg;
  logic signed [39:0] vx_ext, vy_ext;

  // Fold the input angle into [-pi/2, pi/2]
  always_comb begin
    z0 = req.cor_ang;
    z1 = (z0 < 0) ? z0 + Q_TWO_PI : z0;
    z2 = (z1 < 0) ? z1 + Q_TWO_PI : z1;
    z3 = (z2 >= Q_TWO_PI) ? z2 - Q_TWO_PI : z2;
    z4 = (z3 > Q_PI) ? z3 - Q_TWO_PI : z3;
    fold_neg = 1'b0;
    fold_z   = z4;
    if (z4 > Q_HALF_PI) begin
      fold_z   = z4 - Q_PI;
      fold_neg = 1'b1;
    end else if (z4 < -Q_HALF_PI) begin
      fold_z   = z4 + Q_PI;
      fold_neg = 1'b1;
    end
  end

  // Step logic
  always_comb begin
    mul_a_abs  = req.mul_a[63] ? -req.mul_a : req.mul_a;
    mul_b_abs  = req.mul_b[32] ? -req.mul_b : req.mul_b;
    div_trial  = {div_rem, div_quo[63]};
    div_ge     = div_trial >= {1'b0, div_den};
    div_diff   = div_trial - {1'b0, div_den};
    cor_dx     = cor_y >>> cor_i;
    cor_dy     = cor_x >>> cor_i;
    cor_atan   = signed'({6'd0, atan_entry(cor_i)});
    cor_dir    = cor_vec ? !(cor_y > 0) : (cor_z >= 0);
    cor_c_full = cor_neg ? -cor_x : cor_x;
    cor_s_full = cor_neg ? -cor_y : cor_y;
    vx_ext     = 40'(req.cor_vx);
    vy_ext     = 40'(req.cor_vy);
  end

  // Busy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      cor_busy <= 1'b0;
    end else begin
      if (req.mul_start) begin
        mul_busy <= 1'b1;
      end else if (mul_busy && mul_cnt == MUL_LAST) begin
        mul_busy <= 1'b0;
      end
      if (req.div_start) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == DIV_LAST) begin
        div_busy <= 1'b0;
      end
      if (req.cor_start) begin
        cor_busy <= 1'b1;
      end else if (cor_busy && cor_i == COR_LAST) begin
        cor_busy <= 1'b0;
      end
    end
  end

  // Multiplier datapath: shift and add on magnitudes
  always_ff @(posedge clk) begin
    if (req.mul_start) begin
      mul_acc    <= '0;
      mul_mcand  <= mul_a_abs;
      mul_mplier <= mul_b_abs[31:0];
      mul_neg    <= req.mul_a[63] ^ req.mul_b[32];
      mul_cnt    <= '0;
    end else if (mul_busy) begin
      if (mul_mplier[0]) begin
        mul_acc <= mul_acc + mul_mcand;
      end
      mul_mcand  <= mul_mcand << 1;
      mul_mplier <= mul_mplier >> 1;
      mul_cnt    <= mul_cnt + 5'd1;
    end
  end

  // Divider datapath: restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (req.div_start) begin
      div_rem <= '0;
      div_quo <= req.div_a[63] ? 64'(-req.div_a) : 64'(req.div_a);
      div_den <= req.div_b;
      div_neg <= req.div_a[63];
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= div_ge ? div_diff[31:0] : div_trial[31:0];
      div_quo <= {div_quo[62:0], div_ge};
      div_cnt <= div_cnt + 6'd1;
    end
  end

  // CORDIC datapath
  always_ff @(posedge clk) begin
    if (req.cor_start) begin
      cor_i   <= '0;
      cor_vec <= req.cor_vec;
      if (req.cor_vec) begin
        cor_neg <= 1'b0;
        if (vx_ext < 0) begin
          if (vy_ext >= 0) begin
            cor_x <= vy_ext;
            cor_y <= -vx_ext;
            cor_z <= Q_HALF_PI;
          end else begin
            cor_x <= -vy_ext;
            cor_y <= vx_ext;
            cor_z <= -Q_HALF_PI;
          end
        end else begin
          cor_x <= vx_ext;
          cor_y <= vy_ext;
          cor_z <= '0;
        end
      end else begin
        cor_x   <= CORDIC_K_Q30;
        cor_y   <= '0;
        cor_z   <= fold_z;
        cor_neg <= fold_neg;
      end
    end else if (cor_busy) begin
      if (cor_dir) begin
        cor_x <= cor_x - cor_dx;
        cor_y <= cor_y + cor_dy;
        cor_z <= cor_z - cor_atan;
      end else begin
        cor_x <= cor_x + cor_dx;
        cor_y <= cor_y - cor_dy;
        cor_z <= cor_z + cor_atan;
      end
      cor_i <= cor_i + 5'd1;
    end
  end

  // Results
  always_comb begin
    rsp.busy  = mul_busy | div_busy | cor_busy;
    rsp.mul_p = mul_neg ? -signed'(mul_acc) : signed'(mul_acc);
    rsp.div_q = div_neg ? -signed'(div_quo) : signed'(div_quo);
    rsp.div_r = div_rem;
    rsp.cor_c = cor_c_full[31:0];
    rsp.cor_s = cor_s_full[31:0];
    rsp.cor_z = cor_z;
  end

endmodule

@@ rtl/lemniscate_tracking_controller.sv @@
// Top level: sequencer, state, configuration registers and output register of the tracker.
// Multiplies and divides run one bit per cycle in the shared serial multiplier and divider;
// a control tick runs 22 multiplies and 14 divides. Transactions are handled one at a
// time; a finished result waits in the output register while the next transaction is
// accepted. Reset restores the register defaults and clears the stored pose and the tick
// count; no clearing pass is needed.
module lemniscate_tracking_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                req_type,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  input  logic signed [15:0]  quat_w,
  output logic                res_valid,
  input  logic                res_ready,
  output logic signed [31:0]  linear_velocity,
  output logic signed [31:0]  angular_velocity,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ltc_pkg::*;

  // Configuration
  logic [15:0] velocity_gain;
  logic [30:0] offset_distance;
  logic [9:0]  tick_period_ms;
  logic [30:0] curve_amplitude;
  logic [15:0] curve_rate;

  // Persistent state
  logic signed [31:0]    stored_x;
  logic signed [31:0]    stored_y;
  logic signed [19:0]    stored_heading;
  logic [TICK_BITS-1:0]  tick_count;

  // Sequencer
  state_t state, state_next;
  logic   launched;
  logic   is_op;
  logic   op_go;
  logic   op_done;
  logic [1:0] pt;

  // Working registers
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [63:0] tmp, tmp2, gain_t;
  logic [28:0]        r0, rp, rf;
  logic [31:0]        amp_s;
  logic [18:0]        phase;
  logic signed [31:0] cos_r, sin_r, cs;
  logic [31:0]        den;
  logic signed [33:0] px0, px1, px2, py0, py1, py2;
  logic signed [46:0] vx, vy;
  logic signed [17:0] c16, s16;
  logic signed [31:0] lin_r, ang_r;

  // Derived values
  logic [9:0]  p_eff;
  logic [30:0] d_eff;
  logic [25:0] u;
  logic [28:0] r_sel;
  logic [29:0] r_back, r_fwd;
  logic signed [63:0] mul_res_shift;
  logic signed [63:0] den_full;
  logic signed [63:0] vel_sum;
  logic        cfg_write;
  reg_idx_t    cfg_idx;

  arith_req_t areq;
  arith_rsp_t arsp;

  ltc_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  function automatic logic signed [46:0] sat45(input logic signed [63:0] v);
    if (v > VEL_LIMIT) begin
      sat45 = 47'(VEL_LIMIT);
    end else if (v < -VEL_LIMIT) begin
      sat45 = 47'(-VEL_LIMIT);
    end else begin
      sat45 = v[46:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Effective period, offset, per-tick phase step, neighbouring phases and result shifts
  always_comb begin
    p_eff  = (tick_period_ms == 10'd0) ? 10'd1 : tick_period_ms;
    d_eff  = (offset_distance == 31'd0) ? 31'd1 : offset_distance;
    u      = 26'(curve_rate * p_eff);
    r_back = (r0 >= 29'(u)) ? 30'(r0) - 30'(u) : 30'(r0) + 30'(PHASE_MOD) - 30'(u);
    r_fwd  = 30'(r0) + 30'(u);
    if (r_fwd >= 30'(PHASE_MOD)) begin
      r_fwd = r_fwd - 30'(PHASE_MOD);
    end
    case (pt)
      2'd0:    r_sel = r0;
      2'd1:    r_sel = rp;
      default: r_sel = rf;
    endcase
    mul_res_shift = arsp.mul_p >>> 30;
    den_full      = mul_res_shift + ONE_Q30;
    vel_sum       = (tmp + arsp.mul_p) >>> 16;
  end

  // Operation handshake with the arithmetic units
  always_comb begin
    is_op   = (state != S_IDLE) && (state != S_OUT);
    op_go   = is_op && !launched;
    op_done = launched && !arsp.busy;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = req_type ? T_NMOD : O_M1;
      O_M1:   if (op_done) state_next = O_M2;
      O_M2:   if (op_done) state_next = O_M3;
      O_M3:   if (op_done) state_next = O_M4;
      O_M4:   if (op_done) state_next = O_VEC;
      O_VEC:  if (op_done) state_next = S_IDLE;
      T_NMOD: if (op_done) state_next = T_RMUL;
      T_RMUL: if (op_done) state_next = T_RMOD;
      T_RMOD: if (op_done) state_next = T_AMP;
      T_AMP:  if (op_done) state_next = P_PH;
      P_PH:   if (op_done) state_next = P_ROT;
      P_ROT:  if (op_done) state_next = P_SS;
      P_SS:   if (op_done) state_next = P_AC;
      P_AC:   if (op_done) state_next = P_XD;
      P_XD:   if (op_done) state_next = P_CS;
      P_CS:   if (op_done) state_next = P_ACS;
      P_ACS:  if (op_done) state_next = P_YD;
      P_YD:   if (op_done) state_next = (pt == 2'd2) ? F_GX : P_PH;
      F_GX:   if (op_done) state_next = F_DX;
      F_DX:   if (op_done) state_next = F_FX;
      F_FX:   if (op_done) state_next = F_GY;
      F_GY:   if (op_done) state_next = F_DY;
      F_DY:   if (op_done) state_next = F_FY;
      F_FY:   if (op_done) state_next = H_ROT;
      H_ROT:  if (op_done) state_next = H_M1;
      H_M1:   if (op_done) state_next = H_M2;
      H_M2:   if (op_done) state_next = H_M3;
      H_M3:   if (op_done) state_next = H_M4;
      H_M4:   if (op_done) state_next = H_WD;
      H_WD:   if (op_done) state_next = S_OUT;
      S_OUT:  if (!res_valid || res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and unit operands
  always_comb begin
    req_ready = (state == S_IDLE);
    areq = '0;
    case (state)
      O_M1: begin
        areq.mul_a = 64'(qw);
        areq.mul_b = 33'(qz);
      end
      O_M2: begin
        areq.mul_a = 64'(qx);
        areq.mul_b = 33'(qy);
      end
      O_M3: begin
        areq.mul_a = 64'(qy);
        areq.mul_b = 33'(qy);
      end
      O_M4: begin
        areq.mul_a = 64'(qz);
        areq.mul_b = 33'(qz);
      end
      O_VEC: begin
        areq.cor_vec = 1'b1;
        areq.cor_vx  = tmp2[35:0];
        areq.cor_vy  = tmp[35:0];
      end
      T_NMOD: begin
        areq.div_a = signed'(64'(tick_count));
        areq.div_b = PHASE_MOD;
      end
      T_RMUL: begin
        areq.mul_a = tmp;
        areq.mul_b = signed'(33'(u));
      end
      T_RMOD: begin
        areq.div_a = tmp;
        areq.div_b = PHASE_MOD;
      end
      T_AMP: begin
        areq.mul_a = SQRT2_Q30;
        areq.mul_b = signed'({2'b00, curve_amplitude});
      end
      P_PH: begin
        areq.div_a = signed'(64'(r_sel));
        areq.div_b = MS_PER_S;
      end
      P_ROT: areq.cor_ang = signed'({3'b000, phase});
      P_SS: begin
        areq.mul_a = 64'(sin_r);
        areq.mul_b = 33'(sin_r);
      end
      P_AC: begin
        areq.mul_a = signed'(64'(amp_s));
        areq.mul_b = 33'(cos_r);
      end
      P_XD, P_YD: begin
        areq.div_a = tmp;
        areq.div_b = den;
      end
      P_CS: begin
        areq.mul_a = 64'(cos_r);
        areq.mul_b = 33'(sin_r);
      end
      P_ACS: begin
        areq.mul_a = signed'(64'(amp_s));
        areq.mul_b = 33'(cs);
      end
      F_GX: begin
        areq.mul_a = 64'(px0) - 64'(stored_x);
        areq.mul_b = signed'(33'(velocity_gain));
      end
      F_GY: begin
        areq.mul_a = 64'(py0) - 64'(stored_y);
        areq.mul_b = signed'(33'(velocity_gain));
      end
      F_DX: begin
        areq.mul_a = 64'(px2) - 64'(px1);
        areq.mul_b = signed'(33'(MS_PER_S));
      end
      F_DY: begin
        areq.mul_a = 64'(py2) - 64'(py1);
        areq.mul_b = signed'(33'(MS_PER_S));
      end
      F_FX, F_FY: begin
        areq.div_a = tmp;
        areq.div_b = {21'd0, p_eff, 1'b0};
      end
      H_ROT: areq.cor_ang = 22'(stored_heading);
      H_M1: begin
        areq.mul_a = 64'(vx);
        areq.mul_b = 33'(c16);
      end
      H_M2: begin
        areq.mul_a = 64'(vy);
        areq.mul_b = 33'(s16);
      end
      H_M3: begin
        areq.mul_a = 64'(vy);
        areq.mul_b = 33'(c16);
      end
      H_M4: begin
        areq.mul_a = 64'(vx);
        areq.mul_b = 33'(s16);
      end
      H_WD: begin
        areq.div_a = tmp;
        areq.div_b = {1'b0, d_eff};
      end
      default: areq = '0;
    endcase
    case (state)
      O_VEC, P_ROT, H_ROT:                     areq.cor_start = op_go;
      T_NMOD, T_RMOD, P_PH, P_XD, P_YD,
      F_FX, F_FY, H_WD:                        areq.div_start = op_go;
      default:                                 areq.mul_start = op_go;
    endcase
  end

  // Configuration port
  always_comb begin
    pready    = 1'b1;
    cfg_write = psel && penable && pwrite;
    cfg_idx   = reg_idx_t'(paddr[4:2]);
    case (cfg_idx)
      REG_GAIN:   prdata = {16'd0, velocity_gain};
      REG_OFFSET: prdata = {1'b0, offset_distance};
      REG_PERIOD: prdata = {22'd0, tick_period_ms};
      REG_AMP:    prdata = {1'b0, curve_amplitude};
      REG_RATE:   prdata = {16'd0, curve_rate};
      default:    prdata = '0;
    endcase
  end

  // Control state, configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      launched        <= 1'b0;
      res_valid       <= 1'b0;
      velocity_gain   <= 16'd768;
      offset_distance <= 31'd3277;
      tick_period_ms  <= 10'd100;
      curve_amplitude <= 31'd196608;
      curve_rate      <= 16'd13107;
      stored_x        <= '0;
      stored_y        <= '0;
      stored_heading  <= '0;
      tick_count      <= '0;
    end else begin
      state    <= state_next;
      launched <= is_op && !op_done;
      if (cfg_write) begin
        case (cfg_idx)
          REG_GAIN:   velocity_gain   <= pwdata[15:0];
          REG_OFFSET: offset_distance <= pwdata[30:0];
          REG_PERIOD: tick_period_ms  <= pwdata[9:0];
          REG_AMP:    curve_amplitude <= pwdata[30:0];
          REG_RATE:   curve_rate      <= pwdata[15:0];
          default: ;
        endcase
      end
      // Store the pose of an odometry transaction
      if (state == S_IDLE && req_valid && !req_type) begin
        stored_x <= pos_x;
        stored_y <= pos_y;
      end
      if (state == O_VEC && op_done) begin
        stored_heading <= (tmp == 64'sd0 && tmp2 == 64'sd0) ? 20'sd0 : arsp.cor_z[19:0];
      end
      // Hand the result to the output register and advance time
      if (state == S_OUT && (!res_valid || res_ready)) begin
        res_valid  <= 1'b1;
        tick_count <= tick_count + 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath captures
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
      qw <= quat_w;
      pt <= 2'd0;
    end
    if (state == S_OUT && (!res_valid || res_ready)) begin
      linear_velocity  <= lin_r;
      angular_velocity <= ang_r;
    end
    if (op_done) begin
      case (state)
        O_M1:   tmp  <= arsp.mul_p;
        O_M2:   tmp  <= (tmp + arsp.mul_p) <<< 1;
        O_M3:   tmp2 <= arsp.mul_p;
        O_M4:   tmp2 <= 64'sd268435456 - ((tmp2 + arsp.mul_p) <<< 1);
        T_NMOD: tmp  <= signed'(64'(arsp.div_r));
        T_RMUL: tmp  <= arsp.mul_p;
        T_RMOD: r0   <= arsp.div_r[28:0];
        T_AMP: begin
          amp_s <= mul_res_shift[31:0];
          rp    <= r_back[28:0];
          rf    <= r_fwd[28:0];
        end
        P_PH:   phase <= arsp.div_q[18:0];
        P_ROT: begin
          cos_r <= arsp.cor_c;
          sin_r <= arsp.cor_s;
        end
        P_SS:   den <= den_full[31:0];
        P_AC:   tmp <= arsp.mul_p;
        P_XD: begin
          case (pt)
            2'd0:    px0 <= arsp.div_q[33:0];
            2'd1:    px1 <= arsp.div_q[33:0];
            default: px2 <= arsp.div_q[33:0];
          endcase
        end
        P_CS:   cs  <= mul_res_shift[31:0];
        P_ACS:  tmp <= arsp.mul_p;
        P_YD: begin
          case (pt)
            2'd0:    py0 <= arsp.div_q[33:0];
            2'd1:    py1 <= arsp.div_q[33:0];
            default: py2 <= arsp.div_q[33:0];
          endcase
          pt <= pt + 2'd1;
        end
        F_GX, F_GY: gain_t <= arsp.mul_p >>> 8;
        F_DX, F_DY: tmp    <= arsp.mul_p;
        F_FX:   vx <= sat45(gain_t + arsp.div_q);
        F_FY:   vy <= sat45(gain_t + arsp.div_q);
        H_ROT: begin
          c16 <= 18'(arsp.cor_c >>> 14);
          s16 <= 18'(arsp.cor_s >>> 14);
        end
        H_M1:   tmp   <= arsp.mul_p;
        H_M2:   lin_r <= sat32(vel_sum);
        H_M3:   tmp   <= arsp.mul_p;
        H_M4:   tmp   <= tmp - arsp.mul_p;
        H_WD:   ang_r <= sat32(arsp.div_q);
        default: ;
      endcase
    end
  end

endmodule

@@ verif/ltc_checker.sv @@
// Checker for the lemniscate tracking controller: pose/tick predictor and velocity scoreboard.
module ltc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic               res_valid,
  input  logic               res_ready,
  input  logic signed [31:0] linear_velocity,
  input  logic signed [31:0] angular_velocity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 fail_count
);
  import ltc_pkg::*;

  typedef struct {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
  } command_t;

  localparam longint TWO_PI_Q  = Q_TWO_PI;
  localparam longint PI_Q      = Q_PI;
  localparam longint HALF_PI_Q = Q_HALF_PI;
  localparam longint K_Q30     = CORDIC_K_Q30;
  localparam longint VLIM      = VEL_LIMIT;
  localparam longint unsigned PMOD = PHASE_MOD;
  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;
  localparam longint ATAN_Q [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                       512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  // Mirrored configuration and pose state
  longint gain_r, offset_r, period_r, amp_r, rate_r;
  longint pose_x, pose_y;
  logic signed [19:0] heading;
  logic [TICK_BITS-1:0] ticks;
  command_t velocity_q [$];
  int mismatches;

  assign pending = velocity_q.size();
  assign fail_count = mismatches;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_at(int i);
    return i <= 16 ? ATAN_Q[i] : 0;
  endfunction

  // Angle in Q16.16 to cosine and sine in Q30
  function automatic void rotate_angle(input longint ang, output longint co,
                                       output longint si);
    longint x, y, z, dx, dy;
    bit neg;
    x = K_Q30; y = 0; z = ang % TWO_PI_Q; neg = 0;
    if (z < 0) z += TWO_PI_Q;
    if (z > PI_Q) z -= TWO_PI_Q;
    if (z > HALF_PI_Q) begin
      z -= PI_Q; neg = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q; neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_at(i);
      end else begin
        x += dx; y -= dy; z += atan_at(i);
      end
    end
    co = neg ? -x : x;
    si = neg ? -y : y;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_at(i);
      end else begin
        x -= dx; y += dy; z -= atan_at(i);
      end
    end
    return z;
  endfunction

  function automatic void lemniscate_at(input longint unsigned r, output longint px,
                                        output longint py);
    longint c, s, as, den;
    longint unsigned prod;
    rotate_angle(longint'(r / 1000), c, s);
    prod = longint'(amp_r) * longint'(SQRT2_Q30);
    as = longint'(prod >> 30);
    den = ((s * s) >>> 30) + ONE_Q30;
    px = (as * c) / den;
    py = (as * ((c * s) >>> 30)) / den;
  endfunction

  // Work out the velocity command for one control tick and advance time
  function automatic command_t predict_command();
    longint unsigned u, n, rn, rp, rf;
    longint p, d, x0, y0, xp, yp, xf, yf, vx, vy, c, s, c16, s16;
    command_t cmd;
    p = period_r != 0 ? period_r : 1;
    d = offset_r != 0 ? offset_r : 1;
    u = longint'(rate_r) * longint'(p);
    n = ticks;
    rn = ((n % PMOD) * u) % PMOD;
    rp = (rn + PMOD - u) % PMOD;
    rf = (rn + u) % PMOD;
    lemniscate_at(rn, x0, y0);
    lemniscate_at(rp, xp, yp);
    lemniscate_at(rf, xf, yf);
    vx = ((gain_r * (x0 - pose_x)) >>> 8) + (xf - xp) * 1000 / (2 * p);
    vy = ((gain_r * (y0 - pose_y)) >>> 8) + (yf - yp) * 1000 / (2 * p);
    vx = clamp(vx, -VLIM, VLIM);
    vy = clamp(vy, -VLIM, VLIM);
    rotate_angle(longint'(heading), c, s);
    c16 = c >>> 14;
    s16 = s >>> 14;
    cmd.lin = 32'(clamp((vx * c16 + vy * s16) >>> 16, I32_MIN, I32_MAX));
    cmd.ang = 32'(clamp((vy * c16 - vx * s16) / d, I32_MIN, I32_MAX));
    ticks = ticks + 1'b1;
    return cmd;
  endfunction

  function automatic void store_pose();
    longint qx, qy, qz, qw, sy, cy, h;
    qx = quat_x; qy = quat_y; qz = quat_z; qw = quat_w;
    sy = 2 * (qw * qz + qx * qy);
    cy = 64'sd268435456 - 2 * (qy * qy + qz * qz);
    pose_x = pos_x;
    pose_y = pos_y;
    h = vector_angle(sy, cy);
    heading = h[19:0];
  endfunction

  function automatic void report(string field, logic signed [31:0] exp_v,
                                 logic signed [31:0] act_v);
    if (mismatches < 10)
      $display("mismatch %s: expected %0d, got %0d", field, exp_v, act_v);
    mismatches++;
  endfunction

  // Track register writes, predict accepted transactions, compare results
  always @(posedge clk) begin
    command_t want;
    if (rst) begin
      gain_r = 768; offset_r = 3277; period_r = 100; amp_r = 196608; rate_r = 13107;
      pose_x = 0; pose_y = 0; heading = '0; ticks = '0;
      mismatches = 0;
      velocity_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[4:2])
          REG_GAIN:   gain_r   = pwdata[15:0];
          REG_OFFSET: offset_r = pwdata[30:0];
          REG_PERIOD: period_r = pwdata[9:0];
          REG_AMP:    amp_r    = pwdata[30:0];
          REG_RATE:   rate_r   = pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        if (req_type) velocity_q.push_back(predict_command());
        else store_pose();
      end
      if (res_valid && res_ready) begin
        if (velocity_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction");
          mismatches++;
        end else begin
          want = velocity_q.pop_front();
          if (want.lin !== linear_velocity) report("linear_velocity", want.lin,
                                                   linear_velocity);
          if (want.ang !== angular_velocity) report("angular_velocity", want.ang,
                                                    angular_velocity);
        end
      end
    end
  end

endmodule

@@ verif/tb_lemniscate_tracking_controller.sv @@
// Testbench top for the lemniscate tracking controller: clock, stimulus and verdict.
module tb_lemniscate_tracking_controller;
  import ltc_pkg::*;

  logic               clk = 0;
  logic               rst;
  logic               req_valid, req_ready, req_type;
  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic               res_valid, res_ready;
  logic signed [31:0] linear_velocity, angular_velocity;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 pending, fail_count;
  int                 cyc;
  logic               quiet;

  lemniscate_tracking_controller dut (.*);
  ltc_checker chk (.*);

  always #2 clk = ~clk;

  // Cycle count and the stretch with no idling on either side
  always @(posedge clk) cyc <= rst ? 0 : cyc + 1;
  assign quiet = cyc >= 150000 && cyc < 300000;

  // Receiver: random stalls plus one long hold-off while random traffic runs
  always @(posedge clk) begin
    int held;
    if (rst) begin
      res_ready <= 1'b0;
      held = 0;
    end else begin
      held++;
      if (held >= 500000 && held < 506000) res_ready <= 1'b0;
      else res_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] g, input logic [31:0] d, input logic [31:0] p,
                           input logic [31:0] a, input logic [31:0] r);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, d);
    write_reg(REG_PERIOD, p);
    write_reg(REG_AMP, a);
    write_reg(REG_RATE, r);
  endtask

  // Offer one transaction, with a random gap before it outside the quiet stretch
  task automatic send(input logic t, input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [15:0] qx, input logic signed [15:0] qy,
                      input logic signed [15:0] qz, input logic signed [15:0] qw);
    while (!quiet && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1; req_type <= t;
    pos_x <= x; pos_y <= y;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic tick();
    send(1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
  endtask

  task automatic random_item();
    logic signed [31:0] x, y;
    if ($urandom_range(1)) begin
      tick();
    end else begin
      if ($urandom_range(3) == 0) begin
        x = $urandom; y = $urandom;
      end else begin
        x = $signed($urandom_range(800000)) - 400000;
        y = $signed($urandom_range(400000)) - 200000;
      end
      send(1'b0, x, y, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Let every expected result arrive, then cover a trailing odometry transaction
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1; req_valid <= 1'b0; req_type <= 1'b0;
    pos_x <= '0; pos_y <= '0; quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first tick on the reset pose, then pose extremes and quaternion corners
    tick();
    tick();
    send(1'b0, 32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    tick();
    send(1'b0, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    tick();
    send(1'b0, 0, 0, 0, 16'sd8192, 16'sd8192, 0);
    tick();
    send(1'b0, 65536, -65536, 0, 0, 16'sd11585, 16'sd11585);
    tick();
    send(1'b0, -65536, 65536, 0, 0, 16'sd16384, 0);
    tick();
    send(1'b0, 196608, 0, 0, 0, -16'sd11585, 16'sd11585);
    tick();
    send(1'b0, 0, 0, 16'sh7fff, 16'sh8000, 0, 16'sd1);
    tick();
    drain();

    // Extremes: all low (zero period and offset), all high, huge velocity, bad index
    configure(0, 0, 0, 0, 0);
    tick(); send(1'b0, 32'sd12345, -32'sd999, 0, 0, 16'sd5000, 16'sd9000); tick();
    drain();
    configure(65535, 32'h7fffffff, 1000, 32'h7fffffff, 65535);
    tick(); send(1'b0, 32'sh80000000, 32'sh80000000, 0, 0, 0, 16'sd16384); tick(); tick();
    drain();
    configure(65535, 1, 1, 32'h7fffffff, 65535);
    tick(); send(1'b0, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 16'sd3000, 16'sd16000); tick();
    drain();
    write_reg(3'd5, 32'hffffffff);
    write_reg(3'd6, 32'd0);
    write_reg(3'd7, 32'h12345678);
    tick();
    drain();

    // Random phases: defaults, all high, all low, typical settings and fully random register words
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(768, 3277, 100, 196608, 13107);
        1: configure(65535, 32'h7fffffff, 1000, 32'h7fffffff, 65535);
        2: configure(0, 0, 0, 0, 0);
        3, 4: configure($urandom_range(2048), $urandom_range(1, 65536), $urandom_range(1, 1000),
                        $urandom_range(1 << 20), $urandom_range(65535));
        default: configure($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      repeat (166) random_item();
      drain();
    end

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Run limit
  initial begin
    #120000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
